>>> rtl/multirate_periodic_task_divider_top_macros.svh
// Assertion helpers shared by the periodic job divider bank.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef MULTIRATE_PERIODIC_TASK_DIVIDER_TOP_MACROS_SVH
`define MULTIRATE_PERIODIC_TASK_DIVIDER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mptd_pkg.sv
// ----------------------------------------------------------------------------
// mptd_pkg
// Shared codes, widths and the cell control struct of the job divider bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mptd_pkg;

  localparam int DATA_W = 32;

  // Command codes of an input word.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_REG  = 2'd1;
  localparam logic [1:0] CMD_REM  = 2'd2;

  // Kind codes of a result word.
  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_SUM  = 2'd1;
  localparam logic [1:0] KIND_REG  = 2'd2;
  localparam logic [1:0] KIND_REM  = 2'd3;

  // Broadcast control from the sequencer to the row of cells.
  typedef struct packed {
    logic count;   // advance every enabled job by one tick
    logic remove;  // free every cell whose ID equals the key
    logic claim;   // selected cell takes a new job
    logic setdiv;  // selected cell takes a new enable and, if enabled, a new divisor
    logic en;      // enable value written with setdiv
  } mptd_ctl_t;

endpackage

`default_nettype wire

>>> rtl/mptd_if.sv
// ----------------------------------------------------------------------------
// mptd_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mptd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] main_clock;
  logic [31:0] period;
  logic [15:0] job_id;

  modport source (output valid, cmd, main_clock, period, job_id, input ready);
  modport sink (input valid, cmd, main_clock, period, job_id, output ready);
endinterface

interface mptd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] result_id;
  logic        ok;
  logic        last;

  modport source (output valid, kind, result_id, ok, last, input ready);
  modport sink (input valid, kind, result_id, ok, last, output ready);
endinterface

`default_nettype wire

>>> rtl/mptd_div.sv
// ----------------------------------------------------------------------------
// mptd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mptd_div
  import mptd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      quot_o,
  output logic [DATA_W-1:0]      rem_o
);

  localparam int SW = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SW-1:0]     step_q, step_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] r_q, r_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh = {r_q, a_q[DATA_W-1]};
    diff   = rem_sh - {1'b0, b_q};
    ge     = !diff[DATA_W];
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    a_d    = a_q;
    r_d    = r_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      a_d    = dividend_i;
      r_d    = '0;
      b_d    = divisor_i;
    end else if (busy_q) begin
      a_d    = {a_q[DATA_W-2:0], ge};
      r_d    = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      step_d = step_q + SW'(1);
      if (step_q == SW'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign quot_o = a_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

>>> rtl/mptd_cell.sv
// ----------------------------------------------------------------------------
// mptd_cell
// One job slot: holds ID, period, enable, divisor and tick count, and passes
// the free-slot and ID-match chains on to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mptd_cell
  import mptd_pkg::*;
#(
  parameter int ID_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mptd_ctl_t          ctl_i,
  input  wire logic               sel_i,
  input  wire logic [ID_BITS-1:0] key_i,
  input  wire logic [DATA_W-1:0]  period_i,
  input  wire logic [DATA_W-1:0]  quot_i,
  input  wire logic               free_i,
  input  wire logic               match_i,
  output logic                    free_o,
  output logic                    match_o,
  output logic                    first_o,
  output logic                    valid_o,
  output logic [ID_BITS-1:0]      id_o,
  output logic [DATA_W-1:0]       period_o,
  output logic                    fire_o
);

  logic               valid_q;
  logic               fire_q;
  logic [ID_BITS-1:0] id_q;
  logic [DATA_W-1:0]  period_q;
  logic               en_q;
  logic [DATA_W-1:0]  div_q;
  logic [DATA_W-1:0]  cnt_q;
  logic [DATA_W-1:0]  cnt_inc;
  logic               hit;
  logic               live;

  assign hit     = valid_q && (id_q == key_i);
  assign live    = valid_q && en_q;
  assign cnt_inc = cnt_q + DATA_W'(1);

  // Chains toward the next cell.
  assign free_o  = free_i | !valid_q;
  assign first_o = !valid_q && !free_i;
  assign match_o = match_i | hit;

  // Occupancy and fire flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fire_q  <= 1'b0;
    end else begin
      if (ctl_i.claim && sel_i) begin
        valid_q <= 1'b1;
      end else if (ctl_i.remove && hit) begin
        valid_q <= 1'b0;
      end
      if (ctl_i.count) begin
        fire_q <= live && (cnt_inc == div_q);
      end
    end
  end

  // Job contents.
  always_ff @(posedge clk_i) begin
    if (ctl_i.claim && sel_i) begin
      id_q     <= key_i;
      period_q <= period_i;
      en_q     <= 1'b0;
    end else if (ctl_i.setdiv && sel_i) begin
      en_q <= ctl_i.en;
      if (ctl_i.en) begin
        div_q <= quot_i;
        cnt_q <= '0;
      end
    end else if (ctl_i.count && live) begin
      cnt_q <= (cnt_inc == div_q) ? '0 : cnt_inc;
    end
  end

  assign valid_o  = valid_q;
  assign id_o     = id_q;
  assign period_o = period_q;
  assign fire_o   = fire_q;

endmodule

`default_nettype wire

>>> rtl/multirate_periodic_task_divider_top.sv
// ----------------------------------------------------------------------------
// multirate_periodic_task_divider_top
// Bank of periodic jobs that divide a base tick into per-job firing events.
// ----------------------------------------------------------------------------
// Each command word is accepted only in the idle state. A register word then
// tries candidate IDs to find a free one (one candidate ID per cycle, checked
// against all cells at once) and queues its ack; when the base clock is
// nonzero, it also computes the divisor in the shared divider. A remove word
// frees the matching cell as it is accepted and queues its ack. A tick word
// goes through counting, the slot scan and the summary. When the clock value
// changes, it first walks the slots and, when the new clock is nonzero, runs
// the shared 32-step divider once per occupied slot. The output side can hold
// a result word back and so stall the sequencer. Command words are taken one
// at a time.
`default_nettype none

`include "multirate_periodic_task_divider_top_macros.svh"

module multirate_periodic_task_divider_top
  import mptd_pkg::*;
#(
  parameter int SLOTS   = 8,
  parameter int ID_BITS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mptd_in_if.sink     in_i,
  mptd_out_if.source  out_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DSCAN = 8'b0000_0010,
    S_DWAIT = 8'b0000_0100,
    S_COUNT = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_SUM   = 8'b0010_0000,
    S_ALLOC = 8'b0100_0000,
    S_ACK   = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      s_q, s_d;
  logic [CW-1:0]      tries_q, tries_d;
  logic [DATA_W-1:0]  clock_now_q, clock_now_d;
  logic [ID_BITS-1:0] cursor_q, cursor_d;
  logic [ID_BITS-1:0] cand_q, cand_d;
  logic [DATA_W-1:0]  period_q, period_d;
  logic               all_ok_q, all_ok_d;
  logic               reg_mode_q, reg_mode_d;
  logic [1:0]         ack_kind_q, ack_kind_d;
  logic [15:0]        ack_id_q, ack_id_d;
  logic               ack_ok_q, ack_ok_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_kind_q, out_kind_d;
  logic [15:0]        out_id_q, out_id_d;
  logic               out_ok_q, out_ok_d;
  logic               out_last_q, out_last_d;

  mptd_ctl_t          ctl;
  logic [SLOTS-1:0]   sel;
  logic [ID_BITS-1:0] key;
  logic [ID_BITS-1:0] rid_key;
  logic [15:0]        cand16;
  logic [15:0]        fire_id16;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      ff_idx;
  logic               in_acc;
  logic               out_free;

  logic [SLOTS:0]     free_chain;
  logic [SLOTS:0]     match_chain;
  logic [SLOTS-1:0]   first_free;
  logic [SLOTS-1:0]   cell_valid;
  logic [SLOTS-1:0]   cell_fire;
  logic [ID_BITS-1:0] cell_id     [SLOTS];
  logic [DATA_W-1:0]  cell_period [SLOTS];

  logic               div_start;
  logic               div_done;
  logic [DATA_W-1:0]  div_a;
  logic [DATA_W-1:0]  quot;
  logic [DATA_W-1:0]  rem;
  logic               set_en;

  // Command words are taken only while the sequencer is idle.
  assign in_i.ready = (state_q == S_IDLE);

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign idx      = s_q[IW-1:0];
  assign set_en   = (rem == '0) && (quot != '0);

  // ID width conversions between the 16-bit ports and the ID_BITS key.
  always_comb begin
    rid_key   = '0;
    cand16    = '0;
    fire_id16 = '0;
    for (int i = 0; i < ID_BITS && i < 16; i++) begin
      rid_key[i]   = in_i.job_id[i];
      cand16[i]    = cand_q[i];
      fire_id16[i] = cell_id[idx][i];
    end
  end

  // Index of the lowest free cell.
  always_comb begin
    ff_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first_free[i]) begin
        ff_idx = IW'(i);
      end
    end
  end

  assign key   = (state_q == S_IDLE) ? rid_key : cand_q;
  assign div_a = (state_q == S_ALLOC) ? period_q : cell_period[idx];

  // Row of job cells.
  assign free_chain[0]  = 1'b0;
  assign match_chain[0] = 1'b0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    mptd_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .sel_i    (sel[g]),
      .key_i    (key),
      .period_i (period_q),
      .quot_i   (quot),
      .free_i   (free_chain[g]),
      .match_i  (match_chain[g]),
      .free_o   (free_chain[g+1]),
      .match_o  (match_chain[g+1]),
      .first_o  (first_free[g]),
      .valid_o  (cell_valid[g]),
      .id_o     (cell_id[g]),
      .period_o (cell_period[g]),
      .fire_o   (cell_fire[g])
    );
  end

  // Shared divider for period / clock.
  mptd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (clock_now_q),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    tries_d     = tries_q;
    clock_now_d = clock_now_q;
    cursor_d    = cursor_q;
    cand_d      = cand_q;
    period_d    = period_q;
    all_ok_d    = all_ok_q;
    reg_mode_d  = reg_mode_q;
    ack_kind_d  = ack_kind_q;
    ack_id_d    = ack_id_q;
    ack_ok_d    = ack_ok_q;
    ctl         = '0;
    sel         = '0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_ok_d    = out_ok_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.cmd)
            CMD_TICK: begin
              all_ok_d   = 1'b1;
              reg_mode_d = 1'b0;
              if (in_i.main_clock != clock_now_q) begin
                clock_now_d = in_i.main_clock;
                s_d         = '0;
                state_d     = S_DSCAN;
              end else begin
                state_d = S_COUNT;
              end
            end
            CMD_REG: begin
              cand_d   = cursor_q + ID_BITS'(1);
              tries_d  = '0;
              period_d = in_i.period;
              state_d  = S_ALLOC;
            end
            CMD_REM: begin
              ctl.remove = 1'b1;
              ack_kind_d = KIND_REM;
              ack_id_d   = in_i.job_id;
              ack_ok_d   = match_chain[SLOTS];
              state_d    = S_ACK;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk the slots and redo the divisor of every occupied one (disable it if the clock is zero).
      S_DSCAN: begin
        if (s_q == CW'(SLOTS)) begin
          state_d = S_COUNT;
        end else if (cell_valid[idx]) begin
          if (clock_now_q == '0) begin
            ctl.setdiv = 1'b1;
            ctl.en     = 1'b0;
            sel[idx]   = 1'b1;
            all_ok_d   = 1'b0;
            s_d        = s_q + CW'(1);
          end else begin
            div_start = 1'b1;
            state_d   = S_DWAIT;
          end
        end else begin
          s_d = s_q + CW'(1);
        end
      end

      S_DWAIT: begin
        if (div_done) begin
          ctl.setdiv = 1'b1;
          ctl.en     = set_en;
          sel[idx]   = 1'b1;
          if (reg_mode_q) begin
            state_d = S_ACK;
          end else begin
            all_ok_d = all_ok_q && set_en;
            s_d      = s_q + CW'(1);
            state_d  = S_DSCAN;
          end
        end
      end

      S_COUNT: begin
        ctl.count = 1'b1;
        s_d       = '0;
        state_d   = S_SCAN;
      end

      // Report fired jobs in slot order.
      S_SCAN: begin
        if (s_q == CW'(SLOTS)) begin
          state_d = S_SUM;
        end else if (cell_fire[idx]) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_FIRE;
            out_id_d    = fire_id16;
            out_ok_d    = 1'b0;
            out_last_d  = 1'b0;
            s_d         = s_q + CW'(1);
          end
        end else begin
          s_d = s_q + CW'(1);
        end
      end

      S_SUM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_SUM;
          out_id_d    = '0;
          out_ok_d    = all_ok_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // Try one candidate ID per cycle.
      S_ALLOC: begin
        ack_kind_d = KIND_REG;
        if (!free_chain[SLOTS]) begin
          ack_id_d = '0;
          ack_ok_d = 1'b0;
          state_d  = S_ACK;
        end else if (!match_chain[SLOTS]) begin
          ctl.claim  = 1'b1;
          sel        = first_free;
          cursor_d   = cand_q;
          ack_id_d   = cand16;
          ack_ok_d   = 1'b1;
          s_d        = CW'(ff_idx);
          reg_mode_d = 1'b1;
          if (clock_now_q != '0) begin
            div_start = 1'b1;
            state_d   = S_DWAIT;
          end else begin
            state_d = S_ACK;
          end
        end else if (tries_q == CW'(SLOTS)) begin
          ack_id_d = '0;
          ack_ok_d = 1'b0;
          state_d  = S_ACK;
        end else begin
          cand_d  = cand_q + ID_BITS'(1);
          tries_d = tries_q + CW'(1);
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = ack_kind_q;
          out_id_d    = ack_id_q;
          out_ok_d    = ack_ok_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      s_q         <= '0;
      tries_q     <= '0;
      clock_now_q <= '0;
      cursor_q    <= '0;
      reg_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s_q         <= s_d;
      tries_q     <= tries_d;
      clock_now_q <= clock_now_d;
      cursor_q    <= cursor_d;
      reg_mode_q  <= reg_mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cand_q     <= cand_d;
    period_q   <= period_d;
    all_ok_q   <= all_ok_d;
    ack_kind_q <= ack_kind_d;
    ack_id_q   <= ack_id_d;
    ack_ok_q   <= ack_ok_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_ok_q   <= out_ok_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.result_id = out_id_q;
  assign out_o.ok        = out_ok_q;
  assign out_o.last      = out_last_q;

  // Checks on the sequencer and the cell row.
  `MPTD_ASSERT_NOW(a_div_done_in_wait, div_done, state_q == S_DWAIT,
    "divider finished outside the wait state")
  `MPTD_ASSERT_NOW(a_first_free_unique, 1'b1, $onehot0(first_free),
    "more than one cell marked as lowest free")
  `MPTD_ASSERT_NEXT(a_claim_fills_cell, ctl.claim, match_chain[SLOTS],
    "claimed ID not found in the cell row")

endmodule

`default_nettype wire
